// ----- design/smpq_pkg.sv -----
package smpq_pkg;

   // Default sizes of the queue.
   localparam int CAPACITY_DEFAULT  = 16;
   localparam int TAG_WIDTH_DEFAULT = 16;

   // Fixed field widths.
   localparam int KEY_WIDTH       = 32;
   localparam int TAG_FIELD_WIDTH = 16;
   localparam int OCC_WIDTH       = 5;
   localparam int STATUS_WIDTH    = 2;

   // Operation carried by an input item.
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_POP    = 1'b1
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Command broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic                        ins;
      logic                        pop;
      logic signed [KEY_WIDTH-1:0] key;
   } cmd_type;

endpackage

// ----- design/stable_min_priority_queue_top.sv -----
// The result of an item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken (rsp_tready); the row
// of cells updates at once, each cell making one key compare against the broadcast key.
// Reset (synchronous, active high) empties the queue and the result register;
// the stored keys and tags are not cleared.
module stable_min_priority_queue_top #(
   parameter int CAPACITY  = smpq_pkg::CAPACITY_DEFAULT,
   parameter int TAG_WIDTH = smpq_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // key [31:0], tag [47:32]
   input  logic [0:0]  req_tuser,  // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_key [31:0], out_tag [47:32], occupancy [52:48]
   output logic [2:0]  rsp_tuser   // found [0], status [2:1]
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam int KW    = smpq_pkg::KEY_WIDTH;

   logic                    accept;
   logic                    full, empty;
   smpq_pkg::cmd_type       cmd;
   logic [TAG_WIDTH-1:0]    new_tag;
   logic [CNT_W-1:0]        count_ff, count_in;
   smpq_pkg::status_type    status;

   logic signed [KW-1:0]    cell_key [CAPACITY];
   logic [TAG_WIDTH-1:0]    cell_tag [CAPACITY];
   logic                    cell_after [CAPACITY];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic signed [KW-1:0]    okey_ff, okey_in;
   logic [15:0]             otag_ff, otag_in;
   logic [1:0]              status_ff, status_in;
   logic [4:0]              occ_ff, occ_in;

   // An item is taken whenever the result register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign empty = count_ff == '0;

   // Command decode for the cell row.
   always_comb begin
      cmd.key = req_tdata[31:0];
      cmd.ins = 1'b0;
      cmd.pop = 1'b0;
      status  = smpq_pkg::STATUS_OK;
      unique case (smpq_pkg::kind_type'(req_tuser[0]))
         smpq_pkg::KIND_INSERT: begin
            cmd.ins = accept && !full;
            if (full) status = smpq_pkg::STATUS_FULL;
         end
         smpq_pkg::KIND_POP: begin
            cmd.pop = accept && !empty;
            if (empty) status = smpq_pkg::STATUS_EMPTY;
         end
         default: ;
      endcase
   end

   assign new_tag = TAG_WIDTH'(req_tdata[47:32]);

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) count_in = count_ff + CNT_W'(1);
      else if (cmd.pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   // Row of sorted cells, smallest key in cell zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KW-1:0]  p_key, n_key;
      logic [TAG_WIDTH-1:0]  p_tag, n_tag;
      logic                  p_after;

      if (i == 0) begin : g_first
         assign p_key   = cmd.key;
         assign p_tag   = new_tag;
         assign p_after = 1'b0;
      end else begin : g_mid
         assign p_key   = cell_key[i-1];
         assign p_tag   = cell_tag[i-1];
         assign p_after = cell_after[i-1];
      end

      if (i == CAPACITY-1) begin : g_last
         assign n_key = cell_key[i];
         assign n_tag = cell_tag[i];
      end else begin : g_inner
         assign n_key = cell_key[i+1];
         assign n_tag = cell_tag[i+1];
      end

      smpq_cell #(
         .CAPACITY  (CAPACITY),
         .TAG_WIDTH (TAG_WIDTH),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .new_tag    (new_tag),
         .prev_key   (p_key),
         .prev_tag   (p_tag),
         .prev_after (p_after),
         .next_key   (n_key),
         .next_tag   (n_tag),
         .key_out    (cell_key[i]),
         .tag_out    (cell_tag[i]),
         .after_out  (cell_after[i])
      );
   end

   // Result register, loaded with every accepted item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      okey_in      = okey_ff;
      otag_in      = otag_ff;
      status_in    = status_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         found_in     = cmd.pop;
         okey_in      = cmd.pop ? cell_key[0] : '0;
         otag_in      = cmd.pop ? 16'(cell_tag[0]) : '0;
         status_in    = status;
         occ_in       = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      okey_ff   <= okey_in;
      otag_ff   <= otag_in;
      status_ff <= status_in;
      occ_ff    <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, occ_ff, otag_ff, okey_ff};
   assign rsp_tuser  = {status_ff, found_ff};

endmodule

// ----- design/smpq_cell.sv -----
module smpq_cell #(
   parameter int CAPACITY  = smpq_pkg::CAPACITY_DEFAULT,
   parameter int TAG_WIDTH = smpq_pkg::TAG_WIDTH_DEFAULT,
   parameter int INDEX     = 0
) (
   input  logic                                  clock,
   input  smpq_pkg::cmd_type                     cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]         count,
   input  logic [TAG_WIDTH-1:0]                  new_tag,
   input  logic signed [smpq_pkg::KEY_WIDTH-1:0] prev_key,
   input  logic [TAG_WIDTH-1:0]                  prev_tag,
   input  logic                                  prev_after,
   input  logic signed [smpq_pkg::KEY_WIDTH-1:0] next_key,
   input  logic [TAG_WIDTH-1:0]                  next_tag,
   output logic signed [smpq_pkg::KEY_WIDTH-1:0] key_out,
   output logic [TAG_WIDTH-1:0]                  tag_out,
   output logic                                  after_out
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic signed [smpq_pkg::KEY_WIDTH-1:0] key_ff, key_in;
   logic [TAG_WIDTH-1:0]                  tag_ff, tag_in;
   logic                                  occupied;

   // The cell holds an entry when its position lies below the count.
   assign occupied = count > CNT_W'(INDEX);

   // The new entry belongs at or before this position when this cell is empty
   // or holds a strictly larger key; equal keys keep the older entry in front.
   assign after_out = !occupied || (cmd.key < key_ff);

   // Insert moves the tail up by one; pop moves the whole row down by one.
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (cmd.ins && after_out) begin
         if (prev_after) begin
            key_in = prev_key;
            tag_in = prev_tag;
         end else begin
            key_in = cmd.key;
            tag_in = new_tag;
         end
      end else if (cmd.pop) begin
         key_in = next_key;
         tag_in = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key_out = key_ff;
   assign tag_out = tag_ff;

endmodule
